### rtl/tvbb_pkg.sv
// ----------------------------------------------------------------------------
// tvbb_pkg: shared types and constants
// Coordinate formats, configuration register indexes and reset values,
// and the lane and merge control bundles.
// ----------------------------------------------------------------------------
package tvbb_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int FRAC_BITS   = 8;
    localparam int COEF_W      = 16;
    localparam int REG_W       = 2 * COEF_W;
    localparam int PROD_W      = COEF_W + COORD_WIDTH;
    localparam int SUM_W       = PROD_W + 2;
    localparam int NUM_AXES    = 3;
    localparam int NUM_REGS    = 2 * NUM_AXES;
    localparam int CFG_IDX_W   = 3;
    localparam int ROUND_BIAS  = (FRAC_BITS > 0) ? (1 << (FRAC_BITS - 1)) : 0;

    typedef logic signed [COORD_WIDTH-1:0] t_coord;
    typedef logic signed [COEF_W-1:0]      t_coef;
    typedef logic [REG_W-1:0]              t_cfg_word;

    localparam t_coord COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam t_coord COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_X_COLS_01    = 3'd0,
        REG_ROW_X_COL2_TRANS = 3'd1,
        REG_ROW_Y_COLS_01    = 3'd2,
        REG_ROW_Y_COL2_TRANS = 3'd3,
        REG_ROW_Z_COLS_01    = 3'd4,
        REG_ROW_Z_COL2_TRANS = 3'd5
    } t_reg_idx;

    // identity matrix
    localparam t_cfg_word RST_ROW_X_COLS_01    = 32'h0000_0100;
    localparam t_cfg_word RST_ROW_X_COL2_TRANS = 32'h0000_0000;
    localparam t_cfg_word RST_ROW_Y_COLS_01    = 32'h0100_0000;
    localparam t_cfg_word RST_ROW_Y_COL2_TRANS = 32'h0000_0000;
    localparam t_cfg_word RST_ROW_Z_COLS_01    = 32'h0000_0000;
    localparam t_cfg_word RST_ROW_Z_COL2_TRANS = 32'h0000_0100;

    typedef struct packed {
        logic en1;
        logic en2;
        logic en3;
    } t_lane_ctl;

    typedef struct packed {
        logic take;
        logic first;
        logic last;
    } t_merge_ctl;

endpackage

### rtl/transformed_vertex_bounding_box.sv
// ----------------------------------------------------------------------------
// transformed_vertex_bounding_box: bounding box of transformed vertices
// Path: the last vertex of a pass runs through the 3 lane stages, then the
//   merge/result register, before its box appears on the output.
// Throughput: one vertex per cycle while o_stall is low; the three axis lanes
//   each run one multiply stage, one add stage and one round/saturate stage.
// Reset (synchronous, active low): identity matrix, empty pipeline, running
//   minima at the most positive and maxima at the most negative value.
// ----------------------------------------------------------------------------
module transformed_vertex_bounding_box (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // vertex request channel
    input  logic                             i_valid,
    output logic                             o_stall,
    input  tvbb_pkg::t_coord                 i_pos_x,
    input  tvbb_pkg::t_coord                 i_pos_y,
    input  tvbb_pkg::t_coord                 i_pos_z,
    input  logic                             i_first_vertex,
    input  logic                             i_last_vertex,
    // box result channel
    output logic                             o_valid,
    input  logic                             i_stall,
    output tvbb_pkg::t_coord                 o_box_min_x,
    output tvbb_pkg::t_coord                 o_box_max_x,
    output tvbb_pkg::t_coord                 o_box_min_y,
    output tvbb_pkg::t_coord                 o_box_max_y,
    output tvbb_pkg::t_coord                 o_box_min_z,
    output tvbb_pkg::t_coord                 o_box_max_z,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tvbb_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  tvbb_pkg::t_cfg_word              i_cfg_data
);

    // ------------------------------------------------------------------
    // Matrix registers. Writes must come only while idle; the block does
    // not enforce it, accepts every cycle, drops an index past the last row.
    // ------------------------------------------------------------------
    tvbb_pkg::t_cfg_word r_cfg [tvbb_pkg::NUM_REGS];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[tvbb_pkg::REG_ROW_X_COLS_01]    <= tvbb_pkg::RST_ROW_X_COLS_01;
            r_cfg[tvbb_pkg::REG_ROW_X_COL2_TRANS] <= tvbb_pkg::RST_ROW_X_COL2_TRANS;
            r_cfg[tvbb_pkg::REG_ROW_Y_COLS_01]    <= tvbb_pkg::RST_ROW_Y_COLS_01;
            r_cfg[tvbb_pkg::REG_ROW_Y_COL2_TRANS] <= tvbb_pkg::RST_ROW_Y_COL2_TRANS;
            r_cfg[tvbb_pkg::REG_ROW_Z_COLS_01]    <= tvbb_pkg::RST_ROW_Z_COLS_01;
            r_cfg[tvbb_pkg::REG_ROW_Z_COL2_TRANS] <= tvbb_pkg::RST_ROW_Z_COL2_TRANS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tvbb_pkg::REG_ROW_X_COLS_01: begin
                    r_cfg[tvbb_pkg::REG_ROW_X_COLS_01] <= i_cfg_data;
                end
                tvbb_pkg::REG_ROW_X_COL2_TRANS: begin
                    r_cfg[tvbb_pkg::REG_ROW_X_COL2_TRANS] <= i_cfg_data;
                end
                tvbb_pkg::REG_ROW_Y_COLS_01: begin
                    r_cfg[tvbb_pkg::REG_ROW_Y_COLS_01] <= i_cfg_data;
                end
                tvbb_pkg::REG_ROW_Y_COL2_TRANS: begin
                    r_cfg[tvbb_pkg::REG_ROW_Y_COL2_TRANS] <= i_cfg_data;
                end
                tvbb_pkg::REG_ROW_Z_COLS_01: begin
                    r_cfg[tvbb_pkg::REG_ROW_Z_COLS_01] <= i_cfg_data;
                end
                tvbb_pkg::REG_ROW_Z_COL2_TRANS: begin
                    r_cfg[tvbb_pkg::REG_ROW_Z_COL2_TRANS] <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control. Stages collapse bubbles: a stage loads when it is
    // empty or its contents move on. Only a vertex that closes a pass
    // needs the result register, so ordinary vertices keep flowing while
    // a finished box waits to be taken.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3;
    logic r_first1, r_first2, r_first3;
    logic r_last1, r_last2, r_last3;
    logic out_free, adv3, en2, en1;

    tvbb_pkg::t_lane_ctl  lane_ctl;
    tvbb_pkg::t_merge_ctl merge_ctl;

    assign out_free = !o_valid || !i_stall;
    assign adv3     = !r_v3 || !r_last3 || out_free;
    assign en2      = !r_v2 || adv3;
    assign en1      = !r_v1 || en2;
    assign o_stall  = !en1;

    assign lane_ctl.en1 = en1;
    assign lane_ctl.en2 = en2;
    assign lane_ctl.en3 = adv3;

    assign merge_ctl.take  = r_v3 && adv3;
    assign merge_ctl.first = r_first3;
    assign merge_ctl.last  = r_last3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // advance the pass flags alongside the lane data
    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_first1 <= i_first_vertex;
            r_last1  <= i_last_vertex;
        end
        if (en2) begin
            r_first2 <= r_first1;
            r_last2  <= r_last1;
        end
        if (adv3) begin
            r_first3 <= r_first2;
            r_last3  <= r_last2;
        end
    end

    // ------------------------------------------------------------------
    // Axis lanes: one matrix row each, side by side on the same vertex.
    // ------------------------------------------------------------------
    tvbb_pkg::t_coord lane_coord [tvbb_pkg::NUM_AXES];

    for (genvar g = 0; g < tvbb_pkg::NUM_AXES; g++) begin : g_lane
        tvbb_lane u_lane (
            .i_clk        (i_clk),
            .i_ctl        (lane_ctl),
            .i_cols_01    (r_cfg[2*g]),
            .i_col2_trans (r_cfg[2*g+1]),
            .i_x          (i_pos_x),
            .i_y          (i_pos_y),
            .i_z          (i_pos_z),
            .o_coord      (lane_coord[g])
        );
    end

    // ------------------------------------------------------------------
    // Merge: running min/max and the held box.
    // ------------------------------------------------------------------
    tvbb_pkg::t_coord box_min [tvbb_pkg::NUM_AXES];
    tvbb_pkg::t_coord box_max [tvbb_pkg::NUM_AXES];

    tvbb_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (merge_ctl),
        .i_coord (lane_coord),
        .i_stall (i_stall),
        .o_valid (o_valid),
        .o_min   (box_min),
        .o_max   (box_max)
    );

    assign o_box_min_x = box_min[0];
    assign o_box_max_x = box_max[0];
    assign o_box_min_y = box_min[1];
    assign o_box_max_y = box_max[1];
    assign o_box_min_z = box_min[2];
    assign o_box_max_z = box_max[2];

endmodule

### rtl/tvbb_lane.sv
// ----------------------------------------------------------------------------
// tvbb_lane: one affine row
// Three-stage dot product of a vertex with one matrix row, rounded to the
// coordinate format and saturated.
// ----------------------------------------------------------------------------
module tvbb_lane (
    input  logic                      i_clk,
    input  tvbb_pkg::t_lane_ctl       i_ctl,
    input  tvbb_pkg::t_cfg_word       i_cols_01,
    input  tvbb_pkg::t_cfg_word       i_col2_trans,
    input  tvbb_pkg::t_coord          i_x,
    input  tvbb_pkg::t_coord          i_y,
    input  tvbb_pkg::t_coord          i_z,
    output tvbb_pkg::t_coord          o_coord
);

    tvbb_pkg::t_coef c0, c1, c2, tr;

    logic signed [tvbb_pkg::PROD_W-1:0] n_p0, n_p1, n_p2;
    logic signed [tvbb_pkg::PROD_W-1:0] r_p0, r_p1, r_p2;
    tvbb_pkg::t_coef                    r_tr;

    logic signed [tvbb_pkg::SUM_W-1:0]  n_a, n_b, r_a, r_b;
    logic signed [tvbb_pkg::SUM_W-1:0]  total, shifted;
    tvbb_pkg::t_coord                   n_coord, r_coord;

    assign c0 = i_cols_01[tvbb_pkg::COEF_W-1:0];
    assign c1 = i_cols_01[tvbb_pkg::REG_W-1:tvbb_pkg::COEF_W];
    assign c2 = i_col2_trans[tvbb_pkg::COEF_W-1:0];
    assign tr = i_col2_trans[tvbb_pkg::REG_W-1:tvbb_pkg::COEF_W];

    // stage 1: products
    always_comb begin
        n_p0 = tvbb_pkg::PROD_W'(c0) * tvbb_pkg::PROD_W'(i_x);
        n_p1 = tvbb_pkg::PROD_W'(c1) * tvbb_pkg::PROD_W'(i_y);
        n_p2 = tvbb_pkg::PROD_W'(c2) * tvbb_pkg::PROD_W'(i_z);
    end

    // stage 2: pairwise sums, translation scaled to product fraction
    always_comb begin
        n_a = tvbb_pkg::SUM_W'(r_p0) + tvbb_pkg::SUM_W'(r_p1);
        n_b = tvbb_pkg::SUM_W'(r_p2)
            + (tvbb_pkg::SUM_W'(r_tr) <<< tvbb_pkg::FRAC_BITS);
    end

    // stage 3: round half up, floor shift, saturate
    always_comb begin
        total   = r_a + r_b + tvbb_pkg::SUM_W'(tvbb_pkg::ROUND_BIAS);
        shifted = total >>> tvbb_pkg::FRAC_BITS;
        if (shifted > tvbb_pkg::SUM_W'(tvbb_pkg::COORD_MAX)) begin
            n_coord = tvbb_pkg::COORD_MAX;
        end else if (shifted < tvbb_pkg::SUM_W'(tvbb_pkg::COORD_MIN)) begin
            n_coord = tvbb_pkg::COORD_MIN;
        end else begin
            n_coord = shifted[tvbb_pkg::COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_p0 <= n_p0;
            r_p1 <= n_p1;
            r_p2 <= n_p2;
            r_tr <= tr;
        end
        if (i_ctl.en2) begin
            r_a <= n_a;
            r_b <= n_b;
        end
        if (i_ctl.en3) begin
            r_coord <= n_coord;
        end
    end

    assign o_coord = r_coord;

endmodule

### rtl/tvbb_merge.sv
// ----------------------------------------------------------------------------
// tvbb_merge: running box and result register
// Folds the lane coordinates into per-axis minima and maxima and holds the
// box of a finished pass until it is taken.
// ----------------------------------------------------------------------------
module tvbb_merge (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tvbb_pkg::t_merge_ctl i_ctl,
    input  tvbb_pkg::t_coord     i_coord [tvbb_pkg::NUM_AXES],
    input  logic                 i_stall,
    output logic                 o_valid,
    output tvbb_pkg::t_coord     o_min [tvbb_pkg::NUM_AXES],
    output tvbb_pkg::t_coord     o_max [tvbb_pkg::NUM_AXES]
);

    tvbb_pkg::t_coord r_min [tvbb_pkg::NUM_AXES];
    tvbb_pkg::t_coord r_max [tvbb_pkg::NUM_AXES];
    tvbb_pkg::t_coord n_min [tvbb_pkg::NUM_AXES];
    tvbb_pkg::t_coord n_max [tvbb_pkg::NUM_AXES];
    tvbb_pkg::t_coord r_box_min [tvbb_pkg::NUM_AXES];
    tvbb_pkg::t_coord r_box_max [tvbb_pkg::NUM_AXES];
    logic             r_valid;

    always_comb begin
        for (int a = 0; a < tvbb_pkg::NUM_AXES; a++) begin
            if (i_ctl.first) begin
                n_min[a] = i_coord[a];
                n_max[a] = i_coord[a];
            end else begin
                n_min[a] = (i_coord[a] < r_min[a]) ? i_coord[a] : r_min[a];
                n_max[a] = (i_coord[a] > r_max[a]) ? i_coord[a] : r_max[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            for (int a = 0; a < tvbb_pkg::NUM_AXES; a++) begin
                r_min[a] <= tvbb_pkg::COORD_MAX;
                r_max[a] <= tvbb_pkg::COORD_MIN;
            end
        end else begin
            if (i_ctl.take) begin
                r_min <= n_min;
                r_max <= n_max;
            end
            // load a box when a pass ends, drop it once taken
            if (i_ctl.take && i_ctl.last) begin
                r_valid   <= 1'b1;
                r_box_min <= n_min;
                r_box_max <= n_max;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_min   = r_box_min;
    assign o_max   = r_box_max;

endmodule

### test/tvbb_box_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tvbb_box_checker: box prediction and comparison
// Watches the vertex, box and configuration channels of the bounding box
// block. Keeps its own matrix and running box, and compares every box the
// block hands out with the oldest predicted one.
// ----------------------------------------------------------------------------
module tvbb_box_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // vertex channel
    input  logic                           i_vtx_valid,
    input  logic                           i_vtx_stall,
    input  tvbb_pkg::t_coord               i_pos_x,
    input  tvbb_pkg::t_coord               i_pos_y,
    input  tvbb_pkg::t_coord               i_pos_z,
    input  logic                           i_first_vertex,
    input  logic                           i_last_vertex,
    // box channel
    input  logic                           i_box_valid,
    input  logic                           i_box_stall,
    input  tvbb_pkg::t_coord               i_box_min_x,
    input  tvbb_pkg::t_coord               i_box_max_x,
    input  tvbb_pkg::t_coord               i_box_min_y,
    input  tvbb_pkg::t_coord               i_box_max_y,
    input  tvbb_pkg::t_coord               i_box_min_z,
    input  tvbb_pkg::t_coord               i_box_max_z,
    // configuration channel
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [tvbb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  tvbb_pkg::t_cfg_word            i_cfg_data,
    // status
    output int                             o_mismatches,
    output int                             o_boxes_pending,
    output int                             o_boxes_checked
);
    import tvbb_pkg::*;

    // field 2*axis holds the minimum, 2*axis+1 the maximum
    typedef logic [2*NUM_AXES-1:0][COORD_WIDTH-1:0] t_box;

    string     box_field_name [2*NUM_AXES] = '{"min_x", "max_x", "min_y", "max_y",
                                               "min_z", "max_z"};
    t_cfg_word matrix_rows [NUM_REGS];
    t_coord    run_lo [NUM_AXES];
    t_coord    run_hi [NUM_AXES];
    t_box      pending_boxes [$];
    int        mismatch_total = 0;
    int        checked_total  = 0;

    // one affine row, rounded half up and clamped to the coordinate range
    function automatic t_coord transform_axis(input int axis, input t_coord x,
                                              input t_coord y, input t_coord z);
        t_coef                   c0, c1, c2, trans;
        logic signed [SUM_W+3:0] acc;
        c0    = matrix_rows[2*axis][COEF_W-1:0];
        c1    = matrix_rows[2*axis][REG_W-1:COEF_W];
        c2    = matrix_rows[2*axis+1][COEF_W-1:0];
        trans = matrix_rows[2*axis+1][REG_W-1:COEF_W];
        acc = c0 * x + c1 * y + c2 * z + (trans <<< FRAC_BITS) + ROUND_BIAS;
        acc = acc >>> FRAC_BITS;
        if (acc > COORD_MAX) return COORD_MAX;
        if (acc < COORD_MIN) return COORD_MIN;
        return t_coord'(acc);
    endfunction

    always @(posedge i_clk) begin : watch
        t_box   got, want;
        t_coord moved [NUM_AXES];
        if (!i_rst_n) begin
            matrix_rows = '{RST_ROW_X_COLS_01, RST_ROW_X_COL2_TRANS, RST_ROW_Y_COLS_01,
                            RST_ROW_Y_COL2_TRANS, RST_ROW_Z_COLS_01, RST_ROW_Z_COL2_TRANS};
            for (int a = 0; a < NUM_AXES; a++) begin
                run_lo[a] = COORD_MAX;
                run_hi[a] = COORD_MIN;
            end
            pending_boxes.delete();
        end else begin
            if (i_box_valid && !i_box_stall) begin
                got = {i_box_max_z, i_box_min_z, i_box_max_y, i_box_min_y,
                       i_box_max_x, i_box_min_x};
                if (pending_boxes.size() == 0) begin
                    $display("%0t: box with nothing expected, actual %h", $time, got);
                    mismatch_total++;
                end else begin
                    want = pending_boxes.pop_front();
                    for (int f = 0; f < 2*NUM_AXES; f++) begin
                        if (got[f] !== want[f]) begin
                            $display("%0t: %s expected %0d actual %0d", $time,
                                     box_field_name[f], $signed(want[f]), $signed(got[f]));
                            mismatch_total++;
                        end
                    end
                    checked_total++;
                end
            end
            // spare indexes are dropped by the block
            if (i_cfg_valid && i_cfg_ready && i_cfg_index < NUM_REGS)
                matrix_rows[i_cfg_index] = i_cfg_data;
            if (i_vtx_valid && !i_vtx_stall) begin
                for (int a = 0; a < NUM_AXES; a++) begin
                    moved[a] = transform_axis(a, i_pos_x, i_pos_y, i_pos_z);
                    if (i_first_vertex) begin
                        run_lo[a] = moved[a];
                        run_hi[a] = moved[a];
                    end else begin
                        if (moved[a] < run_lo[a]) run_lo[a] = moved[a];
                        if (moved[a] > run_hi[a]) run_hi[a] = moved[a];
                    end
                end
                if (i_last_vertex)
                    pending_boxes.push_back({run_hi[2], run_lo[2], run_hi[1], run_lo[1],
                                             run_hi[0], run_lo[0]});
            end
        end
        o_mismatches    <= mismatch_total;
        o_boxes_pending <= pending_boxes.size();
        o_boxes_checked <= checked_total;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: regression for the transformed vertex bounding box
// Streams vertex passes through a series of model matrices (identity,
// saturating, half-scale rounding, extreme and random coefficients) with
// random gaps and output stalls; the box checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import tvbb_pkg::*;

    localparam int NUM_PHASES       = 8;
    localparam int PHASE_ITEMS      = 216;
    localparam int HOLD_PHASE       = 2;     // phase that opens with the long hold-off
    localparam int PAUSE_PHASE      = 4;     // phase where the sender drains mid-way
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int HOLD_BURST       = 48;
    localparam int SETTLE_CYCLES    = 8;
    localparam int QUIET_LIMIT      = 2000;

    // indexes past the matrix; writes to them must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(NUM_REGS);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(NUM_REGS + 1);

    typedef enum {
        MAT_IDENTITY,
        MAT_SATURATE,
        MAT_HALF,
        MAT_ALL_MAX,
        MAT_ALL_MIN,
        MAT_ZERO,
        MAT_RANDOM,
        MAT_SMALL
    } t_matrix_kind;

    t_matrix_kind phase_kinds [NUM_PHASES] = '{MAT_IDENTITY, MAT_RANDOM, MAT_SMALL,
                                               MAT_ALL_MAX, MAT_SMALL, MAT_ALL_MIN,
                                               MAT_RANDOM, MAT_ZERO};

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic                 vtx_valid  = 1'b0;
    logic                 vtx_stall;
    t_coord               pos_x      = '0;
    t_coord               pos_y      = '0;
    t_coord               pos_z      = '0;
    logic                 first_vtx  = 1'b0;
    logic                 last_vtx   = 1'b0;
    logic                 box_valid;
    logic                 box_stall  = 1'b0;
    t_coord               box_min_x, box_max_x, box_min_y, box_max_y, box_min_z, box_max_z;
    logic                 cfg_valid  = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index  = '0;
    t_cfg_word            cfg_data   = '0;

    int mismatches, boxes_pending, boxes_checked;
    bit idle_on          = 1'b1;
    int long_holds_asked = 0;
    int long_holds_done  = 0;
    int vertices_sent    = 0;
    int settings_loaded  = 0;

    transformed_vertex_bounding_box uut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (vtx_valid),
        .o_stall        (vtx_stall),
        .i_pos_x        (pos_x),
        .i_pos_y        (pos_y),
        .i_pos_z        (pos_z),
        .i_first_vertex (first_vtx),
        .i_last_vertex  (last_vtx),
        .o_valid        (box_valid),
        .i_stall        (box_stall),
        .o_box_min_x    (box_min_x),
        .o_box_max_x    (box_max_x),
        .o_box_min_y    (box_min_y),
        .o_box_max_y    (box_max_y),
        .o_box_min_z    (box_min_z),
        .o_box_max_z    (box_max_z),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data)
    );

    tvbb_box_checker boxes_chk (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_vtx_valid     (vtx_valid),
        .i_vtx_stall     (vtx_stall),
        .i_pos_x         (pos_x),
        .i_pos_y         (pos_y),
        .i_pos_z         (pos_z),
        .i_first_vertex  (first_vtx),
        .i_last_vertex   (last_vtx),
        .i_box_valid     (box_valid),
        .i_box_stall     (box_stall),
        .i_box_min_x     (box_min_x),
        .i_box_max_x     (box_max_x),
        .i_box_min_y     (box_min_y),
        .i_box_max_y     (box_max_y),
        .i_box_min_z     (box_min_z),
        .i_box_max_z     (box_max_z),
        .i_cfg_valid     (cfg_valid),
        .i_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .o_mismatches    (mismatches),
        .o_boxes_pending (boxes_pending),
        .o_boxes_checked (boxes_checked)
    );

    initial begin : clock_gen
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Value generators
    // ------------------------------------------------------------------------

    // lean on the extremes and on small values; the rest spans all 16 bits
    function automatic t_coord rand_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return '0;
            3, 4:    return t_coord'($urandom_range(0, 1023) - 512);
            default: return t_coord'($urandom);
        endcase
    endfunction

    // coefficient within +/-2.0 so that not every result clamps
    function automatic t_coef small_coef();
        return t_coef'($urandom_range(0, 1023) - 512);
    endfunction

    // ------------------------------------------------------------------------
    // Vertex requests
    // ------------------------------------------------------------------------

    // Draw a gap, present the vertex and hold it until the block takes it.
    // Keep valid high across back-to-back requests.
    task automatic send_vertex(input t_coord x, input t_coord y, input t_coord z,
                               input logic first, input logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            vtx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vtx_valid <= 1'b1;
        pos_x     <= x;
        pos_y     <= y;
        pos_z     <= z;
        first_vtx <= first;
        last_vtx  <= last;
        do @(posedge clk); while (vtx_stall);
        vertices_sent++;
    endtask

    // Drop valid and wait until every predicted box is out, then let any
    // vertex still in the lanes (one that emits nothing) run through.
    task automatic wait_drained();
        vtx_valid <= 1'b0;
        @(posedge clk);
        while (boxes_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Mostly well-formed passes: first on the opening vertex, last on the
    // closing one. A few passes drop the first flag so boxes accumulate, and
    // about one in ten carries random flags.
    task automatic run_passes(input int count);
        int   sent, len;
        logic noisy, first, last;
        sent = 0;
        while (sent < count) begin
            len   = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
            noisy = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < len; k++) begin
                first = (k == 0) && ($urandom_range(0, 9) != 0);
                last  = (k == len - 1);
                if (noisy) begin
                    first = 1'($urandom_range(0, 1));
                    last  = 1'($urandom_range(0, 1));
                end
                send_vertex(rand_coord(), rand_coord(), rand_coord(), first, last);
            end
            sent += len;
        end
    endtask

    // ------------------------------------------------------------------------
    // Configuration requests (only while the block is idle)
    // ------------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_cfg_word data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // Build a matrix of the given kind and write all six rows, framed by two
    // writes to spare indexes that the block must ignore.
    task automatic load_matrix(input t_matrix_kind kind);
        t_cfg_word rows [NUM_REGS];
        case (kind)
            MAT_IDENTITY: rows = '{RST_ROW_X_COLS_01, RST_ROW_X_COL2_TRANS, RST_ROW_Y_COLS_01,
                                   RST_ROW_Y_COL2_TRANS, RST_ROW_Z_COLS_01,
                                   RST_ROW_Z_COL2_TRANS};
            // x pushed up, y pulled down, z scaled by almost 128
            MAT_SATURATE: rows = '{32'h0000_0100, 32'h7FFF_0000, 32'h0100_0000,
                                   32'h8000_0000, 32'h0000_0000, 32'h0000_7FFF};
            // +0.5 and -0.5 scales expose the half-up rounding
            MAT_HALF:     rows = '{32'h0000_0080, 32'h0000_0000, 32'hFF80_0000,
                                   32'h0000_0000, 32'h0000_0000, 32'h0000_0080};
            MAT_ALL_MAX:  rows = '{default: 32'h7FFF_7FFF};
            MAT_ALL_MIN:  rows = '{default: 32'h8000_8000};
            MAT_ZERO: begin
                for (int r = 0; r < NUM_REGS; r++)
                    rows[r] = (r % 2) ? {16'($urandom), 16'h0000} : '0;
            end
            MAT_SMALL: begin
                for (int r = 0; r < NUM_REGS; r++)
                    rows[r] = (r % 2) ? {16'($urandom), small_coef()}
                                      : {small_coef(), small_coef()};
            end
            default: begin
                for (int r = 0; r < NUM_REGS; r++)
                    rows[r] = $urandom;
            end
        endcase
        write_reg(REG_SPARE_LO, $urandom);
        write_reg(REG_ROW_X_COLS_01,    rows[REG_ROW_X_COLS_01]);
        write_reg(REG_ROW_X_COL2_TRANS, rows[REG_ROW_X_COL2_TRANS]);
        write_reg(REG_ROW_Y_COLS_01,    rows[REG_ROW_Y_COLS_01]);
        write_reg(REG_ROW_Y_COL2_TRANS, rows[REG_ROW_Y_COL2_TRANS]);
        write_reg(REG_ROW_Z_COLS_01,    rows[REG_ROW_Z_COLS_01]);
        write_reg(REG_ROW_Z_COL2_TRANS, rows[REG_ROW_Z_COL2_TRANS]);
        write_reg(REG_SPARE_HI, $urandom);
        cfg_valid <= 1'b0;
        settings_loaded++;
    endtask

    // ------------------------------------------------------------------------
    // Box receiver: random stall before each box, plus a long hold-off on
    // request from the stimulus. The hold-off is counted here, not by the
    // sender, which keeps offering vertices meanwhile.
    // ------------------------------------------------------------------------
    initial begin : box_drain
        int hold;
        forever begin
            if (long_holds_done != long_holds_asked) begin
                long_holds_done++;
                hold = LONG_HOLD_CYCLES;
            end else begin
                hold = idle_on ? $urandom_range(0, 7) : 0;
            end
            if (hold > 0) begin
                box_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            box_stall <= 1'b0;
            do @(posedge clk); while (!box_valid && long_holds_done == long_holds_asked);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when no request moves on any channel for too long
    // ------------------------------------------------------------------------
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((vtx_valid && !vtx_stall) || (box_valid && !box_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("transformed_vertex_bounding_box regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus and verdict
    // ------------------------------------------------------------------------
    initial begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Identity after reset. Open with a closing vertex that has no first
        // flag: it merges into the reset sentinels.
        send_vertex(16'sh0100, 16'sh0200, -16'sh0300, 1'b0, 1'b1);
        // no restart after an emission: the previous box keeps growing
        send_vertex(-16'sh0100, 16'sh0000, 16'sh0000, 1'b0, 1'b1);
        // first and last on one vertex
        send_vertex(COORD_MAX, COORD_MIN, 16'sh0000, 1'b1, 1'b1);
        send_vertex(COORD_MIN, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
        send_vertex(16'sh0001, -16'sh0001, COORD_MIN, 1'b0, 1'b0);
        send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1'b0, 1'b1);
        wait_drained();

        // clamp at both ends of the range
        load_matrix(MAT_SATURATE);
        send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1, 1'b1);
        send_vertex(COORD_MIN, COORD_MAX, COORD_MIN, 1'b1, 1'b1);
        send_vertex(16'sh0000, 16'sh0000, 16'sh0000, 1'b1, 1'b1);
        wait_drained();

        // half-way products round toward plus infinity
        load_matrix(MAT_HALF);
        send_vertex(16'sh0001, 16'sh0001, 16'sh0001, 1'b1, 1'b0);
        send_vertex(-16'sh0001, -16'sh0001, -16'sh0001, 1'b0, 1'b0);
        send_vertex(16'sh0003, -16'sh0003, 16'sh0005, 1'b0, 1'b1);
        send_vertex(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1, 1'b1);
        wait_drained();

        load_matrix(MAT_ALL_MAX);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1);
        send_vertex(COORD_MAX, COORD_MIN, 16'sh0000, 1'b1, 1'b1);
        wait_drained();

        load_matrix(MAT_ALL_MIN);
        send_vertex(COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, 1'b1);
        send_vertex(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, 1'b1);

        // Random phases, one matrix each; every third one runs without idling
        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_on <= (p % 3 != 2);
            wait_drained();
            load_matrix(phase_kinds[p]);
            if (p == HOLD_PHASE) begin
                // hold the output while single-vertex passes keep coming,
                // so the lanes fill and the block stalls its input
                long_holds_asked <= long_holds_asked + 1;
                repeat (HOLD_BURST)
                    send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'b1, 1'b1);
            end
            run_passes(PHASE_ITEMS / 2);
            if (p == PAUSE_PHASE)
                wait_drained();
            run_passes(PHASE_ITEMS / 2);
        end
        wait_drained();

        $display("covered %0d vertices and %0d checked boxes over %0d matrix settings",
                 vertices_sent, boxes_checked, settings_loaded);
        $display("with sentinel merge, saturation, half-up rounding, spare index writes, "
                 , "%0d long output hold-off", long_holds_asked);
        if (mismatches == 0 && boxes_pending == 0) begin
            $display("transformed_vertex_bounding_box regression: pass");
        end else begin
            $display("transformed_vertex_bounding_box regression: fail");
        end
        $finish;
    end

endmodule
